// ===== hdl/tdpb_pkg.sv =====
// shared types and constants for the tail-drop packet buffer timing block
// no dependencies; used by every module of the block by scoped name
`default_nettype none

package tdpb_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned LIMIT_W         = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } t_state;

    // commands from the controller to the ring, never both in one cycle
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_cmd;

    typedef struct packed {
        logic empty;
        logic full;     // occupancy at or above the effective limit
    } t_ring_status;

endpackage

`default_nettype wire

// ===== hdl/tail_drop_packet_buffer_timing.sv =====
// channel   dir  beat contents
// s stream  in   tdata: arrival_time [31:0], service_time [63:32]
// m stream  out  tdata: serve_start [31:0]; tuser: dropped [0]
// cfg       in   cfg_wdata: buffer_limit [6:0], written when cfg_we is high
//
// a packet is taken in the idle state, then the check state retires finish times and decides:
// the retire loop walks the ring memory one entry per cycle through its head read port
// the input is taken again once the result sits in the output register
// the result register holds until taken; a stalled output holds the decision cycle
// synchronous active-low reset empties the ring and sets the limit to 64; no clearing pass
// tail-drop packet buffer timing top level: ring memory plus controller
// depends on tdpb_pkg, tdpb_ring, tdpb_ctrl
`default_nettype none

module tail_drop_packet_buffer_timing #(
    parameter int unsigned QUEUE_DEPTH = tdpb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [63:0]                  i_s_tdata,   // arrival_time, service_time
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [tdpb_pkg::TIME_W-1:0]       o_m_tdata,   // serve_start
    output logic                              o_m_tuser,   // dropped
    input  wire logic                         i_cfg_we,
    input  wire logic [tdpb_pkg::LIMIT_W-1:0] i_cfg_wdata
);

    tdpb_pkg::t_ring_cmd            ring_cmd;
    tdpb_pkg::t_ring_status         ring_status;
    logic [tdpb_pkg::TIME_W-1:0]    push_data;
    logic [tdpb_pkg::TIME_W-1:0]    head_data;

    tdpb_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (ring_cmd),
        .i_push_data (push_data),
        .o_head_data (head_data),
        .o_status    (ring_status)
    );

    tdpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_cmd       (ring_cmd),
        .o_push_data (push_data),
        .i_head_data (head_data),
        .i_status    (ring_status)
    );

endmodule

`default_nettype wire

// ===== hdl/tdpb_ring.sv =====
// finish-time ring: synchronous memory, head/tail pointers, occupancy and limit register
// depends on tdpb_pkg
`default_nettype none

module tdpb_ring #(
    parameter int unsigned QUEUE_DEPTH = tdpb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tdpb_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  wire tdpb_pkg::t_ring_cmd           i_cmd,
    input  wire logic [tdpb_pkg::TIME_W-1:0]   i_push_data,
    output logic [tdpb_pkg::TIME_W-1:0]        o_head_data,
    output tdpb_pkg::t_ring_status             o_status
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMP_W = (OCC_W > tdpb_pkg::LIMIT_W) ? OCC_W : tdpb_pkg::LIMIT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(QUEUE_DEPTH);

    logic [tdpb_pkg::TIME_W-1:0]  mem [QUEUE_DEPTH];
    logic [tdpb_pkg::TIME_W-1:0]  r_head_data;
    logic [IDX_W-1:0]             r_head;
    logic [IDX_W-1:0]             n_head;
    logic [IDX_W-1:0]             r_tail;
    logic [IDX_W-1:0]             n_tail;
    logic [OCC_W-1:0]             r_occ;
    logic [OCC_W-1:0]             n_occ;
    logic [tdpb_pkg::LIMIT_W-1:0] r_limit;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (i_cmd.pop) begin
            n_head = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
            n_occ  = r_occ - 1'b1;
        end else if (i_cmd.push) begin
            n_tail = (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
            n_occ  = r_occ + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_limit <= tdpb_pkg::LIMIT_RESET;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // read port follows the next head, so the entry at the head is ready each cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= i_push_data;
        end
        r_head_data <= mem[n_head];
    end

    assign o_head_data    = r_head_data;
    assign o_status.empty = (r_occ == '0);
    assign o_status.full  = (CMP_W'(r_occ) >= CMP_W'(r_limit)) || (r_occ == OCC_MAX);

endmodule

`default_nettype wire

// ===== hdl/tdpb_ctrl.sv =====
// per-packet controller: retire loop, drop decision, start and saturated finish time
// depends on tdpb_pkg; drives tdpb_ring through its command struct
`default_nettype none

module tdpb_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [63:0]                 i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [tdpb_pkg::TIME_W-1:0]      o_m_tdata,
    output logic                             o_m_tuser,
    output tdpb_pkg::t_ring_cmd              o_cmd,
    output logic [tdpb_pkg::TIME_W-1:0]      o_push_data,
    input  wire logic [tdpb_pkg::TIME_W-1:0] i_head_data,
    input  wire tdpb_pkg::t_ring_status      i_status
);

    localparam int unsigned TW = tdpb_pkg::TIME_W;

    tdpb_pkg::t_state r_state, n_state;

    logic [TW-1:0] r_arr, n_arr;
    logic [TW-1:0] r_svc, n_svc;
    logic [TW-1:0] r_last, n_last;
    logic          r_out_valid, n_out_valid;
    logic          r_out_drop, n_out_drop;
    logic [TW-1:0] r_out_start, n_out_start;
    logic [TW-1:0] start;
    logic [TW:0]   sum;
    logic [TW-1:0] finish;
    logic          retire;
    logic          out_free;

    assign start    = i_status.empty ? r_arr : r_last;
    assign sum      = {1'b0, start} + {1'b0, r_svc};
    assign finish   = sum[TW] ? '1 : sum[TW-1:0];
    assign retire   = !i_status.empty && (i_head_data <= r_arr);
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_arr       = r_arr;
        n_svc       = r_svc;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_drop  = r_out_drop;
        n_out_start = r_out_start;
        o_cmd       = '0;
        unique case (r_state)
            tdpb_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_arr   = i_s_tdata[TW-1:0];
                    n_svc   = i_s_tdata[2*TW-1:TW];
                    n_state = tdpb_pkg::ST_CHECK;
                end
            end
            tdpb_pkg::ST_CHECK: begin
                // one retired finish time per cycle, then decide once no head is due and the output is free
                if (retire) begin
                    o_cmd.pop = 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = tdpb_pkg::ST_IDLE;
                    if (i_status.full) begin
                        n_out_drop  = 1'b1;
                        n_out_start = '0;
                    end else begin
                        n_out_drop  = 1'b0;
                        n_out_start = start;
                        n_last      = finish;
                        o_cmd.push  = 1'b1;
                    end
                end
            end
            default: n_state = tdpb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_arr       <= n_arr;
        r_svc       <= n_svc;
        r_out_drop  <= n_out_drop;
        r_out_start <= n_out_start;
    end

    assign o_s_tready  = (r_state == tdpb_pkg::ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_start;
    assign o_m_tuser   = r_out_drop;
    assign o_push_data = finish;

endmodule

`default_nettype wire

// ===== hdl/tdpb_checker.sv =====
// port-level checks for the tail-drop packet buffer timing block, bound to the top level
// depends on tdpb_pkg and tail_drop_packet_buffer_timing
`default_nettype none

module tdpb_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_s_tvalid,
    input wire logic                         o_s_tready,
    input wire logic                         o_m_tvalid,
    input wire logic                         i_m_tready,
    input wire logic [tdpb_pkg::TIME_W-1:0]  o_m_tdata,
    input wire logic                         o_m_tuser
);

    // a result beat held back stays unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // a dropped packet reports start time zero
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("dropped packet with nonzero start time");

    // one packet at a time: input closes right after a beat is taken
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready straight after an accepted beat");

    // reset leaves no result pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind tail_drop_packet_buffer_timing tdpb_checker u_tdpb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ===== dv/tdpb_checker.sv =====
// outcome checker for the tail-drop packet buffer timing block: watches the input,
// output and limit-write ports, predicts drop flag and start time per packet beat
// depends on tdpb_pkg for the ring depth, time and limit widths and the limit reset value
`default_nettype none

module tdpb_outcome_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    input  wire logic                         i_s_tready,
    input  wire logic [63:0]                  i_s_tdata,   // arrival_time, service_time
    input  wire logic                         i_m_tvalid,
    input  wire logic                         i_m_tready,
    input  wire logic [tdpb_pkg::TIME_W-1:0]  i_m_tdata,   // serve_start
    input  wire logic                         i_m_tuser,   // dropped
    input  wire logic                         i_cfg_we,
    input  wire logic [tdpb_pkg::LIMIT_W-1:0] i_cfg_wdata,
    output int                                o_errors,
    output int                                o_outstanding
);

    localparam int unsigned RING_DEPTH = tdpb_pkg::QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic                        dropped;
        logic [tdpb_pkg::TIME_W-1:0] serve_start;
    } t_outcome;

    logic [tdpb_pkg::TIME_W-1:0]  finish_times [RING_DEPTH];
    int unsigned                  head_pos;
    int unsigned                  tail_pos;
    int unsigned                  queued;
    logic [tdpb_pkg::TIME_W-1:0]  newest_finish;
    logic [tdpb_pkg::LIMIT_W-1:0] limit_reg;
    t_outcome                     pending_outcomes [$];
    t_outcome                     oldest;
    int                           mismatches = 0;

    // retire finished packets, then either drop or queue the new one
    task automatic admit_packet(input logic [tdpb_pkg::TIME_W-1:0] arrival,
                                input logic [tdpb_pkg::TIME_W-1:0] service);
        int unsigned               cap;
        logic [tdpb_pkg::TIME_W:0] sum;
        t_outcome                  res;
        cap = (limit_reg > RING_DEPTH) ? RING_DEPTH : limit_reg;
        while (queued > 0 && finish_times[head_pos] <= arrival) begin
            head_pos = (head_pos + 1) % RING_DEPTH;
            queued--;
        end
        if (queued >= cap) begin
            res.dropped     = 1'b1;
            res.serve_start = '0;
        end else begin
            res.dropped     = 1'b0;
            res.serve_start = (queued == 0) ? arrival : newest_finish;
            sum = {1'b0, res.serve_start} + {1'b0, service};
            newest_finish = sum[tdpb_pkg::TIME_W] ? '1 : sum[tdpb_pkg::TIME_W-1:0];
            finish_times[tail_pos] = newest_finish;
            tail_pos = (tail_pos + 1) % RING_DEPTH;
            queued++;
        end
        pending_outcomes.insert(pending_outcomes.size(), res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (finish_times[i]) finish_times[i] = '0;
            head_pos      = 0;
            tail_pos      = 0;
            queued        = 0;
            newest_finish = '0;
            limit_reg     = tdpb_pkg::LIMIT_RESET;
            pending_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                limit_reg = i_cfg_wdata;
            end
            // compare before predicting: a result never belongs to a beat of the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: dropped %0b serve_start %0d",
                                 i_m_tuser, i_m_tdata);
                    end
                end else begin
                    oldest = pending_outcomes[0];
                    pending_outcomes.delete(0);
                    if (oldest.dropped !== i_m_tuser || oldest.serve_start !== i_m_tdata) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result mismatch: dropped exp %0b got %0b, ",
                                      "serve_start exp %0d got %0d"},
                                     oldest.dropped, i_m_tuser, oldest.serve_start, i_m_tdata);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                admit_packet(i_s_tdata[31:0], i_s_tdata[63:32]);
            end
        end
        o_errors      <= mismatches;
        o_outstanding <= pending_outcomes.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb_tail_drop_packet_buffer_timing.sv =====
// testbench top for the tail-drop packet buffer timing block: clock, reset, packet
// stimulus with random idling on both sides, limit writes between phases, verdict
// depends on tdpb_pkg, tail_drop_packet_buffer_timing and tdpb_outcome_checker
`default_nettype none

module tb_tail_drop_packet_buffer_timing;

    localparam int RUN_LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_COUNT      = 11;
    localparam int PHASE_PACKETS    = 128;

    logic                         i_clk;
    logic                         i_rst_n   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [63:0]                  s_tdata   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [tdpb_pkg::TIME_W-1:0]  m_tdata;
    logic                         m_tuser;
    logic                         cfg_we    = 1'b0;
    logic [tdpb_pkg::LIMIT_W-1:0] cfg_wdata = tdpb_pkg::LIMIT_RESET;

    int          errors;
    int          outstanding;
    int unsigned packets_sent  = 0;
    int unsigned results_taken = 0;
    int          src_idle_pct  = 24;
    int          sink_idle_pct = 24;

    tail_drop_packet_buffer_timing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    tdpb_outcome_checker outcome_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        if (m_tvalid && m_tready) begin
            results_taken <= results_taken + 1;
        end
    end

    initial begin
        repeat (RUN_LIMIT_CYCLES) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_packet(input logic [31:0] arrival, input logic [31:0] service);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {service, arrival};
        do @(posedge i_clk); while (!s_tready);
        packets_sent++;
    endtask

    // limit changes only once every packet has come back out
    task automatic write_limit(input logic [tdpb_pkg::LIMIT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (packets_sent != results_taken) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] advance_ticks(input logic [31:0] now, input int unsigned step);
        logic [32:0] sum;
        sum = {1'b0, now} + 33'(step);
        return sum[32] ? '1 : sum[31:0];
    endfunction

    initial begin
        logic [tdpb_pkg::LIMIT_W-1:0] phase_limits [PHASE_COUNT];
        logic [31:0] now_ticks;
        logic [31:0] svc_ticks;
        int unsigned gap_max;
        int unsigned svc_max;
        int unsigned back_step;
        int          roll;

        phase_limits = '{7'd1, 7'd64, 7'd2, 7'd127, 7'd5, 7'd65, 7'd3, 7'd16, 7'd8, 7'd0, 7'd0};
        phase_limits[9]  = $urandom_range(0, 127);
        phase_limits[10] = $urandom_range(0, 127);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit, zero times, saturation, time going backwards
        send_packet(32'd0, 32'd0);
        send_packet(32'd0, 32'd5);
        send_packet(32'd1, 32'd10);
        send_packet(32'd2, 32'hFFFF_FFFF);
        send_packet(32'd3, 32'd1);
        send_packet(32'd0, 32'd0);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 32'd0);
        // zero limit drops everything, and the max arrival empties the ring
        write_limit(7'd0);
        send_packet(32'hFFFF_FFFF, 32'd7);
        send_packet(32'd100, 32'd3);
        write_limit(7'd1);
        send_packet(32'd100, 32'd10);
        send_packet(32'd105, 32'd1);
        send_packet(32'd110, 32'd1);
        // limit above the ring size
        write_limit(7'd127);
        send_packet(32'd200, 32'd7);
        send_packet(32'd200, 32'd7);
        send_packet(32'd200, 32'd7);
        send_packet(32'h5555_5555, 32'hAAAA_AAAA);
        send_packet(32'hAAAA_AAAA, 32'h5555_5555);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // drain the ring with a dropped max-arrival beat so the time base can restart
            write_limit(7'd0);
            send_packet(32'hFFFF_FFFF, $urandom());
            write_limit(phase_limits[p]);
            src_idle_pct  = (p == 3) ? 0 : 24;
            sink_idle_pct = (p == 3) ? 0 : 24;
            now_ticks = $urandom();
            gap_max   = $urandom_range(1, 40);
            svc_max   = gap_max * $urandom_range(1, 4);
            for (int k = 0; k < PHASE_PACKETS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    // long gap, retires a deep queue in one go
                    now_ticks = advance_ticks(now_ticks, $urandom_range(0, 70 * svc_max));
                end else if (roll < 5) begin
                    back_step = $urandom_range(1, 200);
                    now_ticks = (now_ticks > back_step) ? now_ticks - back_step : '0;
                end else if (roll >= 15) begin
                    now_ticks = advance_ticks(now_ticks, $urandom_range(0, gap_max));
                end
                // full-range service only at the tail of a phase, it clogs the queue
                if (k >= PHASE_PACKETS - 5) begin
                    svc_ticks = $urandom();
                end else if ($urandom_range(0, 99) < 5) begin
                    svc_ticks = '0;
                end else begin
                    svc_ticks = $urandom_range(0, svc_max);
                end
                send_packet(now_ticks, svc_ticks);
            end
        end

        s_tvalid <= 1'b0;
        while (packets_sent != results_taken) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
